### hw/rtl/wpm_pkg.sv
// shared types and constants of the wildcard pattern matcher
`timescale 1ns / 1ps

package wpm_pkg;

  // request codes carried in req_type
  typedef enum logic [1:0] {
    REQ_APPEND  = 2'd0,
    REQ_TEXT    = 2'd1,
    REQ_CLEAR   = 2'd2,
    REQ_RESTART = 2'd3
  } req_type_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEED,
    ST_PROP,
    ST_DONE
  } state_e;

  // wildcard bytes
  localparam logic [7:0] StarByte = 8'd42;
  localparam logic [7:0] AnyByte  = 8'd63;

  // controls broadcast to every cell
  typedef struct packed {
    logic       seed;     // load the row from the old row and the text byte
    logic       restart;  // seed clears the row instead of taking a text byte
    logic       prop;     // stars pick up the bit of the left neighbour
    logic [7:0] ch;       // text byte being matched
  } cell_ctrl_t;

endpackage

### hw/rtl/wpm_if.sv
// valid/ready channel interfaces for request and response beats
`timescale 1ns / 1ps

interface wpm_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] ch;

  modport source (output valid, output req_type, output ch, input ready);
  modport sink   (input valid, input req_type, input ch, output ready);
endinterface

interface wpm_rsp_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflow;

  modport source (output valid, output matched, output pattern_overflow, input ready);
  modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

### hw/rtl/wpm_cell.sv
// one pattern position: stored byte and its prefix match bit
`timescale 1ns / 1ps

module wpm_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wpm_pkg::cell_ctrl_t ctrl_i,
  input  logic                wr_en_i,
  input  logic [7:0]          wr_byte_i,
  input  logic                valid_i,
  input  logic                left_i,
  output logic                bit_o
);

  logic [7:0] pat_q;
  logic       bit_q;
  logic       bit_d;
  logic       is_star;
  logic       hit;

  // pattern byte store
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      pat_q <= wr_byte_i;
    end
  end

  assign is_star = (pat_q == wpm_pkg::StarByte);
  assign hit     = (pat_q == ctrl_i.ch) || (pat_q == wpm_pkg::AnyByte);

  // match bit update: cells past the pattern end clear; seed from the old row, then let stars pick up the left bit
  always_comb begin
    bit_d = bit_q;
    if (!valid_i) begin
      if (ctrl_i.seed || ctrl_i.prop) begin
        bit_d = 1'b0;
      end
    end else if (ctrl_i.seed) begin
      if (ctrl_i.restart) begin
        bit_d = 1'b0;
      end else if (is_star) begin
        bit_d = bit_q;
      end else begin
        bit_d = left_i & hit;
      end
    end else if (ctrl_i.prop && is_star) begin
      bit_d = bit_q | left_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else begin
      bit_q <= bit_d;
    end
  end

  assign bit_o = bit_q;

endmodule

### hw/rtl/wildcard_pattern_matcher.sv
// wildcard pattern matcher: row of pattern cells and its sequencer
// sequence: accept, a seed step, a propagation step per pattern byte, and a result step
//   that waits for a free response register; a dropped append goes straight to the result step
// requests: no new request beat is taken until the last one's response is registered; the
//   propagation steps let star bits travel one cell per cycle along the chain
// reset: pattern length zero, match row cleared, text empty; pattern bytes are not reset
`timescale 1ns / 1ps

module wildcard_pattern_matcher #(
  parameter int MAX_PATTERN = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  wpm_req_if.sink   req_i,
  wpm_rsp_if.source rsp_o
);

  localparam int LenW = $clog2(MAX_PATTERN + 1);
  localparam int IdxW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  wpm_pkg::state_e    state_q, state_d;
  logic [LenW-1:0]    len_q, len_d;
  logic [LenW-1:0]    cnt_q, cnt_d;
  logic               text_empty_q, text_empty_d;
  logic               restart_q, restart_d;
  logic               ovf_q, ovf_d;
  logic [7:0]         ch_q, ch_d;
  logic               out_valid_q, out_valid_d;
  logic               out_match_q, out_match_d;
  logic               out_ovf_q, out_ovf_d;

  logic               accept;
  logic               full;
  logic               append_ok;
  logic               out_free;
  logic               whole;
  logic [IdxW-1:0]    last_idx;
  logic               left0;
  wpm_pkg::cell_ctrl_t ctrl;

  logic [MAX_PATTERN-1:0] row;
  logic [MAX_PATTERN-1:0] valid_mask;

  assign accept    = req_i.valid && req_i.ready;
  assign full      = (len_q == LenW'(MAX_PATTERN));
  assign append_ok = accept && (wpm_pkg::req_type_e'(req_i.req_type) == wpm_pkg::REQ_APPEND)
                     && !full;
  assign out_free  = !out_valid_q || rsp_o.ready;

  // row of cells
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic left;
    if (k == 0) begin : g_first
      assign left = left0;
    end else begin : g_rest
      assign left = row[k-1];
    end
    assign valid_mask[k] = (LenW'(k) < len_q);

    wpm_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .wr_en_i   (append_ok && (len_q == LenW'(k))),
      .wr_byte_i (req_i.ch),
      .valid_i   (valid_mask[k]),
      .left_i    (left),
      .bit_o     (row[k])
    );
  end

  // left input of the first cell: empty-text flag on seed, restart boundary on propagation
  assign left0 = (state_q == wpm_pkg::ST_SEED) ? text_empty_q : restart_q;

  assign ctrl.seed    = (state_q == wpm_pkg::ST_SEED);
  assign ctrl.restart = restart_q;
  assign ctrl.prop    = (state_q == wpm_pkg::ST_PROP);
  assign ctrl.ch      = ch_q;

  // whole-pattern match from the last valid cell
  assign last_idx = IdxW'(len_q - LenW'(1));
  assign whole    = (len_q == '0) ? text_empty_q : row[last_idx];

  // sequencer
  always_comb begin
    state_d      = state_q;
    len_d        = len_q;
    cnt_d        = cnt_q;
    text_empty_d = text_empty_q;
    restart_d    = restart_q;
    ovf_d        = ovf_q;
    ch_d         = ch_q;
    out_valid_d  = out_valid_q;
    out_match_d  = out_match_q;
    out_ovf_d    = out_ovf_q;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      wpm_pkg::ST_IDLE: begin
        if (accept) begin
          ch_d  = req_i.ch;
          ovf_d = 1'b0;
          case (wpm_pkg::req_type_e'(req_i.req_type))
            wpm_pkg::REQ_APPEND: begin
              if (full) begin
                ovf_d   = 1'b1;
                state_d = wpm_pkg::ST_DONE;
              end else begin
                len_d     = len_q + LenW'(1);
                restart_d = 1'b1;
                state_d   = wpm_pkg::ST_SEED;
              end
            end
            wpm_pkg::REQ_TEXT: begin
              restart_d = 1'b0;
              state_d   = wpm_pkg::ST_SEED;
            end
            wpm_pkg::REQ_CLEAR: begin
              len_d     = '0;
              restart_d = 1'b1;
              state_d   = wpm_pkg::ST_SEED;
            end
            default: begin
              restart_d = 1'b1;
              state_d   = wpm_pkg::ST_SEED;
            end
          endcase
        end
      end
      wpm_pkg::ST_SEED: begin
        text_empty_d = restart_q;
        cnt_d        = len_q;
        state_d      = (len_q == '0) ? wpm_pkg::ST_DONE : wpm_pkg::ST_PROP;
      end
      wpm_pkg::ST_PROP: begin
        cnt_d = cnt_q - LenW'(1);
        if (cnt_q == LenW'(1)) begin
          state_d = wpm_pkg::ST_DONE;
        end
      end
      wpm_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_match_d = whole;
          out_ovf_d   = ovf_q;
          state_d     = wpm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wpm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= wpm_pkg::ST_IDLE;
      len_q        <= '0;
      cnt_q        <= '0;
      text_empty_q <= 1'b1;
      restart_q    <= 1'b1;
      ovf_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      len_q        <= len_d;
      cnt_q        <= cnt_d;
      text_empty_q <= text_empty_d;
      restart_q    <= restart_d;
      ovf_q        <= ovf_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ch_q        <= ch_d;
    out_match_q <= out_match_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign req_i.ready            = (state_q == wpm_pkg::ST_IDLE);
  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.matched          = out_match_q;
  assign rsp_o.pattern_overflow = out_ovf_q;

`ifndef ASSERT_OFF
  // a dropped append leaves the pattern alone and goes straight to the result
  a_ovf_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && wpm_pkg::req_type_e'(req_i.req_type) == wpm_pkg::REQ_APPEND && full)
    |=> (state_q == wpm_pkg::ST_DONE) && $stable(len_q))
    else $error("dropped append changed state");

  // propagation never runs with an exhausted count
  a_prop_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wpm_pkg::ST_PROP) |-> (cnt_q != '0))
    else $error("propagation with zero count");

  // cells past the pattern end hold no match bit once idle
  a_row_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wpm_pkg::ST_IDLE) |-> ((row & ~valid_mask) == '0))
    else $error("match bit set past pattern end");
`endif

endmodule

### verif/wildcard_pattern_matcher_test.sv
// self-checking testbench of the wildcard pattern matcher
`timescale 1ns / 1ps

module wildcard_pattern_matcher_test;

  localparam int          MaxPattern = 64;
  localparam int          RandItems  = 630;
  localparam int          HoldCycles = 400;
  localparam int          IdleLimit  = 3000;
  localparam int          DrainWait  = MaxPattern + 8;
  localparam int          ShownErrs  = 10;
  localparam logic [7:0]  NulByte    = 8'h00;
  localparam logic [7:0]  FullByte   = 8'hff;
  localparam logic [7:0]  LowAlpha   = 8'h61;  // 'a'

  // one response beat as predicted or typed in
  typedef struct packed {
    logic matched;
    logic ovf;
  } verdict_t;

  // one row of directed stimulus, repeated reps times
  typedef struct {
    wpm_pkg::req_type_e req;
    logic [7:0]         ch;
    int unsigned        reps;
    bit                 typed;
    logic               matched;
    logic               ovf;
  } dir_row_t;

  // directed rows: typed rows carry their own expectation, the rest use the predictor
  localparam int NumRows = 25;
  dir_row_t dir_rows [NumRows] = '{
    // empty pattern, empty text
    '{wpm_pkg::REQ_RESTART, NulByte,  1, 1'b1, 1'b1, 1'b0},
    // empty pattern never matches a text byte
    '{wpm_pkg::REQ_TEXT,    FullByte, 1, 1'b1, 1'b0, 1'b0},
    '{wpm_pkg::REQ_CLEAR,   FullByte, 1, 1'b1, 1'b1, 1'b0},
    // single star matches empty and any text
    '{wpm_pkg::REQ_APPEND,  wpm_pkg::StarByte, 1, 1'b1, 1'b1, 1'b0},
    '{wpm_pkg::REQ_TEXT,    NulByte,  1, 1'b1, 1'b1, 1'b0},
    // star then question: empty text no longer matches
    '{wpm_pkg::REQ_APPEND,  wpm_pkg::AnyByte,  1, 1'b1, 1'b0, 1'b0},
    '{wpm_pkg::REQ_TEXT,    FullByte, 1, 1'b0, 1'b0, 1'b0},
    '{wpm_pkg::REQ_TEXT,    wpm_pkg::AnyByte,  1, 1'b0, 1'b0, 1'b0},
    '{wpm_pkg::REQ_APPEND,  NulByte,  1, 1'b0, 1'b0, 1'b0},
    // wildcard bytes inside the text are plain bytes
    '{wpm_pkg::REQ_TEXT,    wpm_pkg::StarByte, 1, 1'b0, 1'b0, 1'b0},
    '{wpm_pkg::REQ_TEXT,    NulByte,  1, 1'b0, 1'b0, 1'b0},
    '{wpm_pkg::REQ_RESTART, 8'haa,    1, 1'b1, 1'b0, 1'b0},
    '{wpm_pkg::REQ_CLEAR,   8'h55,    1, 1'b1, 1'b1, 1'b0},
    // single literal byte
    '{wpm_pkg::REQ_APPEND,  FullByte, 1, 1'b1, 1'b0, 1'b0},
    '{wpm_pkg::REQ_TEXT,    FullByte, 1, 1'b0, 1'b0, 1'b0},
    '{wpm_pkg::REQ_TEXT,    FullByte, 1, 1'b0, 1'b0, 1'b0},
    // full store of stars, then appends that are dropped
    '{wpm_pkg::REQ_CLEAR,   NulByte,  1, 1'b1, 1'b1, 1'b0},
    '{wpm_pkg::REQ_APPEND,  wpm_pkg::StarByte, MaxPattern, 1'b1, 1'b1, 1'b0},
    '{wpm_pkg::REQ_APPEND,  LowAlpha, 1, 1'b1, 1'b1, 1'b1},
    '{wpm_pkg::REQ_TEXT,    LowAlpha, 1, 1'b1, 1'b1, 1'b0},
    '{wpm_pkg::REQ_APPEND,  wpm_pkg::AnyByte,  1, 1'b0, 1'b0, 1'b0},
    '{wpm_pkg::REQ_RESTART, FullByte, 1, 1'b1, 1'b1, 1'b0},
    // full store of question marks against a text one byte longer than the store
    '{wpm_pkg::REQ_CLEAR,   wpm_pkg::AnyByte,  1, 1'b1, 1'b1, 1'b0},
    '{wpm_pkg::REQ_APPEND,  wpm_pkg::AnyByte,  MaxPattern, 1'b0, 1'b0, 1'b0},
    '{wpm_pkg::REQ_TEXT,    NulByte,  MaxPattern + 1, 1'b0, 1'b0, 1'b0}
  };

  logic clk_i;
  logic rst_ni;

  wpm_req_if req_ch ();
  wpm_rsp_if rsp_ch ();

  wildcard_pattern_matcher #(
    .MAX_PATTERN(MaxPattern)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .rsp_o (rsp_ch)
  );

  // predictor state
  logic [7:0]  pat_bytes [MaxPattern];
  int unsigned pat_len;
  logic [63:0] prefix_row;
  logic        no_text;

  verdict_t    verdicts_q [$];
  int unsigned sent_beats;
  int unsigned errors;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_off_req;

  // clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // row seeded from the leading stars of the pattern
  function automatic logic [63:0] star_seed();
    logic [63:0] seed;
    seed = '0;
    for (int k = 0; k < pat_len; k++) begin
      if (pat_bytes[k] != wpm_pkg::StarByte) break;
      seed[k] = 1'b1;
    end
    return seed;
  endfunction

  // advance the predicted matcher by one request beat
  function automatic verdict_t step_matcher(wpm_pkg::req_type_e r, logic [7:0] c);
    verdict_t    v;
    logic [63:0] nrow;
    logic        left_new;
    logic        left_old;
    logic        hit;
    v.ovf = 1'b0;
    case (r)
      wpm_pkg::REQ_APPEND: begin
        if (pat_len < MaxPattern) begin
          pat_bytes[pat_len] = c;
          pat_len++;
          prefix_row = star_seed();
          no_text    = 1'b1;
        end else begin
          v.ovf = 1'b1;
        end
      end
      wpm_pkg::REQ_TEXT: begin
        nrow     = '0;
        left_new = 1'b0;
        left_old = no_text;
        for (int k = 0; k < pat_len; k++) begin
          if (pat_bytes[k] == wpm_pkg::StarByte) begin
            hit = left_new | prefix_row[k];
          end else begin
            hit = left_old & ((c == pat_bytes[k]) || (pat_bytes[k] == wpm_pkg::AnyByte));
          end
          nrow[k]  = hit;
          left_new = hit;
          left_old = prefix_row[k];
        end
        prefix_row = nrow;
        no_text    = 1'b0;
      end
      wpm_pkg::REQ_CLEAR: begin
        pat_len    = 0;
        prefix_row = '0;
        no_text    = 1'b1;
      end
      default: begin
        prefix_row = star_seed();
        no_text    = 1'b1;
      end
    endcase
    v.matched = (pat_len == 0) ? no_text : prefix_row[pat_len - 1];
    return v;
  endfunction

  task automatic flag_error(string what);
    errors++;
    if (errors <= ShownErrs) $display("%0t: %s", $realtime, what);
  endtask

  // drive one request beat, wait for its handshake and record the expectation
  task automatic send_beat(wpm_pkg::req_type_e r, logic [7:0] c, bit typed = 1'b0,
                           logic tm = 1'b0, logic to = 1'b0);
    verdict_t v;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= r;
    req_ch.ch       <= c;
    do @(posedge clk_i); while (!req_ch.ready);
    v = step_matcher(r, c);
    if (typed) begin
      v.matched = tm;
      v.ovf     = to;
    end
    verdicts_q.push_back(v);
    sent_beats++;
  endtask

  // receiver: random stalls, plus one long hold-off on request
  always begin
    @(negedge clk_i);
    if (hold_off_req) begin
      rsp_ch.ready <= 1'b0;
      repeat (HoldCycles) @(negedge clk_i);
      hold_off_req = 1'b0;
    end
    rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // compare every response beat with the oldest expectation
  always @(posedge clk_i) begin : check_rsp
    verdict_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (verdicts_q.size() == 0) begin
        flag_error($sformatf("response beat with nothing expected: matched %b overflow %b",
                             rsp_ch.matched, rsp_ch.pattern_overflow));
      end else begin
        want = verdicts_q.pop_front();
        if (rsp_ch.matched !== want.matched || rsp_ch.pattern_overflow !== want.ovf) begin
          flag_error($sformatf("matched exp %b got %b, overflow exp %b got %b",
                               want.matched, rsp_ch.matched, want.ovf,
                               rsp_ch.pattern_overflow));
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk_i);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("wildcard_pattern_matcher regression: fail");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    int unsigned base;
    int unsigned phase;
    int unsigned plen;
    int unsigned roll;
    logic [7:0]  pat_q [$];
    logic [7:0]  text_q [$];
    rst_ni          = 1'b0;
    req_ch.valid    = 1'b0;
    req_ch.req_type = wpm_pkg::REQ_RESTART;
    req_ch.ch       = NulByte;
    rsp_ch.ready    = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_off_req    = 1'b0;
    sent_beats      = 0;
    errors          = 0;
    pat_len         = 0;
    prefix_row      = '0;
    no_text         = 1'b1;
    foreach (pat_bytes[k]) pat_bytes[k] = NulByte;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed rows, no idling
    foreach (dir_rows[i]) begin
      repeat (dir_rows[i].reps) begin
        send_beat(dir_rows[i].req, dir_rows[i].ch, dir_rows[i].typed,
                  dir_rows[i].matched, dir_rows[i].ovf);
      end
    end

    // random sequences; the receiver first holds off to fill the block
    base         = sent_beats;
    hold_off_req = 1'b1;
    while (sent_beats - base < RandItems) begin
      phase = ((sent_beats - base) / 120) % 4;
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase

      if ($urandom_range(0, 9) == 0) begin
        // noise: any request with any byte
        repeat ($urandom_range(1, 4)) begin
          send_beat(wpm_pkg::req_type_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
      end else begin
        // fresh pattern of mostly short length
        send_beat(wpm_pkg::REQ_CLEAR, 8'($urandom_range(0, 255)));
        roll = $urandom_range(0, 19);
        if (roll == 0)      plen = $urandom_range(9, MaxPattern);
        else if (roll == 1) plen = 0;
        else                plen = $urandom_range(1, 8);
        pat_q.delete();
        repeat (plen) begin
          roll = $urandom_range(0, 9);
          if (roll < 3)      pat_q.push_back(wpm_pkg::StarByte);
          else if (roll < 5) pat_q.push_back(wpm_pkg::AnyByte);
          else if (roll < 9) pat_q.push_back(LowAlpha + 8'($urandom_range(0, 3)));
          else               pat_q.push_back(8'($urandom_range(0, 255)));
          send_beat(wpm_pkg::REQ_APPEND, pat_q[$]);
        end
        if (plen == MaxPattern && $urandom_range(0, 1) == 1) begin
          repeat ($urandom_range(1, 3)) begin
            send_beat(wpm_pkg::REQ_APPEND, 8'($urandom_range(0, 255)));
          end
        end

        // text built to fit the pattern, sometimes spoilt by one byte
        text_q.delete();
        foreach (pat_q[i]) begin
          if (pat_q[i] == wpm_pkg::StarByte) begin
            repeat ($urandom_range(0, 2)) text_q.push_back(LowAlpha + 8'($urandom_range(0, 3)));
          end else if (pat_q[i] == wpm_pkg::AnyByte) begin
            text_q.push_back(8'($urandom_range(0, 255)));
          end else begin
            text_q.push_back(pat_q[i]);
          end
        end
        if (text_q.size() > 0 && $urandom_range(0, 2) == 0) begin
          text_q[$urandom_range(0, text_q.size() - 1)] = LowAlpha + 8'($urandom_range(0, 3));
        end
        foreach (text_q[i]) send_beat(wpm_pkg::REQ_TEXT, text_q[i]);

        // restart and try a short free-running text
        if ($urandom_range(0, 2) == 0) begin
          send_beat(wpm_pkg::REQ_RESTART, 8'($urandom_range(0, 255)));
          repeat ($urandom_range(0, 6)) begin
            send_beat(wpm_pkg::REQ_TEXT, LowAlpha + 8'($urandom_range(0, 3)));
          end
        end
      end
    end

    @(negedge clk_i);
    req_ch.valid <= 1'b0;

    // drain outstanding responses, then a short quiet period
    while (verdicts_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (errors == 0) begin
      $display("wildcard_pattern_matcher regression: pass");
    end else begin
      $display("wildcard_pattern_matcher regression: fail");
    end
    $finish;
  end

endmodule
